@@ hdl/ardt_pkg.sv @@
package ardt_pkg;

  // field widths fixed by the request format
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned LEVEL_W     = 2;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  // request kinds
  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_END   = 1'b1;

  // check_level codes
  localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_HALT = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_CHECK_LEVEL = 1'b0;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic clr_cnt;
    logic inc_cnt;
    logic rd_en;
    logic clear_wr;
    logic commit;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_last;
    logic item_active;
    logic out_busy;
  } status_t;

endpackage

@@ hdl/ardt_ram.sv @@
module ardt_ram #(
  parameter int unsigned WIDTH = 50,
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ardt_ctrl.sv @@
module ardt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ardt_pkg::status_t status_i,
  output ardt_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_COMMIT,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        cmd_o.inc_cnt  = 1'b1;
        if (status_i.cnt_last) begin
          cmd_o.clr_cnt = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          cmd_o.clr_cnt   = 1'b1;
          state_d         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!status_i.item_active) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.inc_cnt = 1'b1;
          if (status_i.cnt_last) begin
            state_d = ST_LAST;
          end
        end
      end
      ST_LAST: begin
        // last entry's read data is evaluated here
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

@@ hdl/ardt_dpath.sv @@
module ardt_dpath #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned THREAD_BITS   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ardt_pkg::cmd_t                      cmd_i,
  output ardt_pkg::status_t                   status_o,
  input  logic                                cmd_kind_i,
  input  logic [ardt_pkg::KEY_W-1:0]          var_key_i,
  input  logic                                key_empty_i,
  input  logic [ardt_pkg::TAG_W-1:0]          thread_tag_i,
  input  logic                                is_write_i,
  input  logic [ardt_pkg::LEVEL_W-1:0]        check_level_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                race_found_o,
  output logic                                halted_o,
  output logic                                table_full_o,
  output logic                                end_unmatched_o
);

  localparam int unsigned IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int unsigned ENTRY_W = ardt_pkg::KEY_W + THREAD_BITS + 2;

  // thread tag cut or widened to the stored width
  logic [THREAD_BITS-1:0] thr_in;
  if (THREAD_BITS > ardt_pkg::TAG_W) begin : g_thr_wide
    assign thr_in = {{(THREAD_BITS - ardt_pkg::TAG_W){1'b0}}, thread_tag_i};
  end else if (THREAD_BITS == ardt_pkg::TAG_W) begin : g_thr_same
    assign thr_in = thread_tag_i;
  end else begin : g_thr_narrow
    assign thr_in = thread_tag_i[THREAD_BITS-1:0];
  end

  // request registers
  logic                         end_q;
  logic [ardt_pkg::KEY_W-1:0]   key_q;
  logic [THREAD_BITS-1:0]       thr_q;
  logic                         wr_q;
  logic                         active_q;

  // scan state
  logic [IDX_W-1:0] cnt_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             any_wr_q, distinct_q;
  logic             free_fnd_q, match_fnd_q;
  logic [IDX_W-1:0] free_idx_q, match_idx_q;
  logic             halt_q, halt_d;

  // output register
  logic out_valid_q;
  logic race_q, halted_q, full_q, unm_q;

  // RAM
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // entry layout: {valid, key, thread, write}
  logic                       e_vld;
  logic [ardt_pkg::KEY_W-1:0] e_key;
  logic [THREAD_BITS-1:0]     e_thr;
  logic                       e_wr;
  logic                       e_hit;

  assign e_vld = ram_rdata[ENTRY_W-1];
  assign e_key = ram_rdata[ENTRY_W-2 -: ardt_pkg::KEY_W];
  assign e_thr = ram_rdata[THREAD_BITS:1];
  assign e_wr  = ram_rdata[0];
  assign e_hit = e_vld && (e_key == key_q);

  logic race_w, full_w, unm_w, commit_en;

  assign race_w    = active_q && (end_q == ardt_pkg::CMD_BEGIN) && (wr_q || any_wr_q) &&
                     distinct_q;
  assign full_w    = active_q && (end_q == ardt_pkg::CMD_BEGIN) && !free_fnd_q;
  assign unm_w     = active_q && (end_q == ardt_pkg::CMD_END) && !match_fnd_q;
  assign commit_en = active_q && ((end_q == ardt_pkg::CMD_END) ? match_fnd_q : free_fnd_q);
  assign halt_d    = halt_q || (race_w && (check_level_i >= ardt_pkg::LEVEL_HALT));

  always_comb begin
    ram_we    = cmd_i.clear_wr || (cmd_i.commit && commit_en);
    ram_waddr = cnt_q;
    ram_wdata = '0;
    if (!cmd_i.clear_wr) begin
      if (end_q == ardt_pkg::CMD_END) begin
        ram_waddr = match_idx_q;
      end else begin
        ram_waddr = free_idx_q;
        ram_wdata = {1'b1, key_q, thr_q, wr_q};
      end
    end
  end

  ardt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  // request, read index and result capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      end_q <= cmd_kind_i;
      key_q <= var_key_i;
      thr_q <= thr_in;
      wr_q  <= is_write_i;
    end
    if (cmd_i.rd_en) begin
      rd_idx_q <= cnt_q;
    end
    if (cmd_i.finish) begin
      race_q   <= race_w;
      halted_q <= halt_d;
      full_q   <= full_w;
      unm_q    <= unm_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      active_q    <= 1'b0;
      any_wr_q    <= 1'b0;
      distinct_q  <= 1'b0;
      free_fnd_q  <= 1'b0;
      match_fnd_q <= 1'b0;
      free_idx_q  <= '0;
      match_idx_q <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;

      if (cmd_i.clr_cnt) begin
        cnt_q <= '0;
      end else if (cmd_i.inc_cnt) begin
        cnt_q <= cnt_q + 1'b1;
      end

      if (cmd_i.load_item) begin
        active_q    <= !halt_q && (check_level_i != ardt_pkg::LEVEL_OFF) && !key_empty_i;
        any_wr_q    <= 1'b0;
        distinct_q  <= 1'b0;
        free_fnd_q  <= 1'b0;
        match_fnd_q <= 1'b0;
      end else if (rd_vld_q) begin
        if (e_hit && e_wr) begin
          any_wr_q <= 1'b1;
        end
        if (e_hit && (e_thr != thr_q)) begin
          distinct_q <= 1'b1;
        end
        if (!e_vld && !free_fnd_q) begin
          free_fnd_q <= 1'b1;
          free_idx_q <= rd_idx_q;
        end
        if (e_hit && (e_thr == thr_q) && (e_wr == wr_q) && !match_fnd_q) begin
          match_fnd_q <= 1'b1;
          match_idx_q <= rd_idx_q;
        end
      end

      if (cmd_i.finish) begin
        halt_q      <= halt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.cnt_last    = (cnt_q == IDX_W'(TABLE_ENTRIES - 1));
  assign status_o.item_active = active_q;
  assign status_o.out_busy    = out_valid_q && !out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign race_found_o    = race_q;
  assign halted_o        = halted_q;
  assign table_full_o    = full_q;
  assign end_unmatched_o = unm_q;

endmodule

@@ hdl/access_race_detect_table.sv @@
// Open-access race detection table.
// Input stream (s_axis): one request per access begin or end. tuser carries
// the kind (begin/end) and the empty-key flag; tdata carries key, thread
// and write mark. Output stream (m_axis): exactly one result per request,
// four flag bits: race found, halted, table full, end unmatched.
// Per checked request the controller sweeps every table entry through the
// single read port of the table RAM, one entry a cycle, with one key
// comparator, then evaluates the last entry, writes any insert or removal
// and loads the result. An ignored request (level 0, empty key, halted)
// skips the sweep and goes straight to loading its result. Requests are
// handled one at a time.
// The result sits in an output register: a stalled receiver does not stop
// the next request being taken; only its own result waits for the slot.
// After reset the table RAM is cleared, one entry a cycle, over all
// TABLE_ENTRIES entries; s_axis_tready_o stays low meanwhile. APB writes
// are taken at any time, but check_level should only change while idle.
// Reset also clears the sticky halt and sets check_level to 0 (off).
module access_race_detect_table #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned THREAD_BITS   = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ardt_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ardt_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ardt_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  // request stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [31:0] var_key, [47:32] thread_tag, [48] is_write, [55:49] zero
  input  logic [ardt_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // [0] cmd, [1] key_empty
  input  logic [ardt_pkg::IN_TUSER_W-1:0]    s_axis_tuser_i,
  // result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [0] race_found, [1] halted, [2] table_full, [3] end_unmatched, [7:4] zero
  output logic [ardt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);

  // check_level register; paddr[2] selects the word
  logic [ardt_pkg::LEVEL_W-1:0] check_level_q;
  logic                         reg_sel;

  assign reg_sel = (paddr[2] == ardt_pkg::REG_CHECK_LEVEL);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? ardt_pkg::APB_DATA_W'(check_level_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_level_q <= ardt_pkg::LEVEL_OFF;
    end else if (psel && penable && pwrite && reg_sel) begin
      check_level_q <= pwdata[ardt_pkg::LEVEL_W-1:0];
    end
  end

  ardt_pkg::cmd_t    cmd;
  ardt_pkg::status_t status;
  logic race_found, halted, table_full, end_unmatched;

  ardt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ardt_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .THREAD_BITS   (THREAD_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cmd_kind_i      (s_axis_tuser_i[0]),
    .var_key_i       (s_axis_tdata_i[31:0]),
    .key_empty_i     (s_axis_tuser_i[1]),
    .thread_tag_i    (s_axis_tdata_i[47:32]),
    .is_write_i      (s_axis_tdata_i[48]),
    .check_level_i   (check_level_q),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .race_found_o    (race_found),
    .halted_o        (halted),
    .table_full_o    (table_full),
    .end_unmatched_o (end_unmatched)
  );

  assign m_axis_tdata_o = {4'b0000, end_unmatched, table_full, halted, race_found};

endmodule
